// File: design/integer_square_root_macros.svh
`ifndef INTEGER_SQUARE_ROOT_MACROS_SVH
`define INTEGER_SQUARE_ROOT_MACROS_SVH

// Checked only while out of reset.
`define ISR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ISR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// File: design/isr_pkg.sv
`timescale 1ns / 1ps

package isr_pkg;

   localparam int RAD_W   = 64;
   localparam int ROOT_W  = (RAD_W + 1) / 2;
   localparam int PAD_W   = 2 * ROOT_W;
   localparam int REM_W   = ROOT_W + 2;
   localparam int LATENCY = ROOT_W;
   localparam int OUT_W   = 32;

   typedef struct packed {
      logic              valid;
      logic [PAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } isr_stage_type;

endpackage

// File: design/isr_cell.sv
`timescale 1ns / 1ps

module isr_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  isr_pkg::isr_stage_type stage_in,
   output isr_pkg::isr_stage_type stage_out
);
   import isr_pkg::*;

   logic              valid_ff;
   logic [PAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;

   logic [PAD_W-1:0]  rad_in;
   logic [REM_W-1:0]  rem_in;
   logic [ROOT_W-1:0] root_in;
   logic [REM_W-1:0]  rem_shift;
   logic [REM_W-1:0]  trial;

   always_comb begin
      rem_shift = {stage_in.rem[REM_W-3:0], stage_in.rad[PAD_W-1 -: 2]};
      trial     = {stage_in.root, 2'b01};
      rad_in    = {stage_in.rad[PAD_W-3:0], 2'b00};
      if (rem_shift >= trial) begin
         rem_in  = rem_shift - trial;
         root_in = {stage_in.root[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_shift;
         root_in = {stage_in.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.rad   = rad_ff;
   assign stage_out.rem   = rem_ff;
   assign stage_out.root  = root_ff;

endmodule

// File: design/integer_square_root.sv
`timescale 1ns / 1ps

// Floor square root of an unsigned 64-bit radicand, 32-bit root. A new
// request is taken every clock cycle (busy stays low); each result appears
// on rsp_root with rsp_valid high for one cycle, in request order, after
// passing through a row of 32 identical registered cells, each settling
// one root bit with a 34-bit compare and subtract. The receiver cannot
// stall the block and must take every result.

module integer_square_root (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [isr_pkg::RAD_W-1:0] req_radicand,
   output logic                      rsp_valid,
   output logic [isr_pkg::OUT_W-1:0] rsp_root
);
   import isr_pkg::*;

   isr_stage_type chain [0:ROOT_W];

   assign busy = 1'b0;

   assign chain[0].valid = start & ~busy;
   assign chain[0].rad   = PAD_W'(req_radicand);
   assign chain[0].rem   = '0;
   assign chain[0].root  = '0;

   for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
      isr_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_in  (chain[i]),
         .stage_out (chain[i+1])
      );
   end

   assign rsp_valid = chain[ROOT_W].valid;
   assign rsp_root  = OUT_W'(chain[ROOT_W].root);

endmodule

// File: design/integer_square_root_checker.sv
`timescale 1ns / 1ps
`include "integer_square_root_macros.svh"

module integer_square_root_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic [isr_pkg::RAD_W-1:0] req_radicand,
   input logic                      rsp_valid,
   input logic [isr_pkg::OUT_W-1:0] rsp_root
);
   import isr_pkg::*;

   localparam int SQ_W = 2 * OUT_W + 2;

   logic [SQ_W-1:0] root_ext;
   logic [SQ_W-1:0] next_ext;
   logic [SQ_W-1:0] root_sq;
   logic [SQ_W-1:0] next_sq;

   always_comb begin
      root_ext = SQ_W'(rsp_root);
      next_ext = root_ext + SQ_W'(1);
      root_sq  = root_ext * root_ext;
      next_sq  = next_ext * next_ext;
   end

   `ISR_ASSERT(a_never_busy, busy == 1'b0, "busy raised")

   `ISR_ASSERT(a_rsp_has_request,
      rsp_valid |-> $past(start && !busy, LATENCY),
      "result without a request at the pipeline latency")

   `ISR_ASSERT(a_root_exact,
      rsp_valid |-> (root_sq <= SQ_W'($past(req_radicand, LATENCY)))
                 && (next_sq > SQ_W'($past(req_radicand, LATENCY))),
      "root is not the floor square root of its request")

   `ISR_ASSERT_ALWAYS(a_reset_flush, reset |=> !rsp_valid,
      "result right after reset")

endmodule

bind integer_square_root integer_square_root_checker u_checker (.*);
